@@ src/tlf_pkg.sv @@
// Package for the tank level text formatter: shared widths, register indexes,
// reset values, the report text table and the segment table of the report.
// No dependencies.
package tlf_pkg;

  localparam int NUM_W = 22;
  localparam int NARROW_W = 16;
  localparam int DEN_W = 8;
  localparam int TXT_W = 6;
  localparam int DIGITS_MAX = 5;

  localparam logic [2:0] REG_ECHO_DIVISOR = 3'd0;
  localparam logic [2:0] REG_EMPTY_DISTANCE = 3'd1;
  localparam logic [2:0] REG_DEAD_ZONE = 3'd2;
  localparam logic [2:0] REG_LITRES_PER_CM = 3'd3;
  localparam logic [2:0] REG_CAPACITY = 3'd4;

  localparam logic [7:0] RST_ECHO_DIVISOR = 8'd3;
  localparam logic [9:0] RST_EMPTY_DISTANCE = 10'd220;
  localparam logic [9:0] RST_DEAD_ZONE = 10'd20;
  localparam logic [11:0] RST_LITRES_PER_CM = 12'd314;
  localparam logic [15:0] RST_CAPACITY = 16'd6000;

  localparam logic [DEN_W-1:0] DEC_BASE = 8'd10;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [TXT_W-1:0] TXT_LAST = 6'd32;

  localparam logic [1:0] VAL_DIST = 2'd0;
  localparam logic [1:0] VAL_HEIGHT = 2'd1;
  localparam logic [1:0] VAL_VOL = 2'd2;

  typedef struct packed {
    logic start;
    logic wide;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic is_num;
    logic [TXT_W-1:0] first;
    logic [TXT_W-1:0] stop;
    logic [1:0] vsel;
  } seg_t;

  // Concatenated report text: "D: LLENO | V: ", "cm | H: ", "cm | V: ", "L\r\n".
  function automatic logic [7:0] txt_char(input logic [TXT_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      6'd0: c = "D";
      6'd1: c = ":";
      6'd2: c = " ";
      6'd3: c = "L";
      6'd4: c = "L";
      6'd5: c = "E";
      6'd6: c = "N";
      6'd7: c = "O";
      6'd8: c = " ";
      6'd9: c = "|";
      6'd10: c = " ";
      6'd11: c = "V";
      6'd12: c = ":";
      6'd13: c = " ";
      6'd14: c = "c";
      6'd15: c = "m";
      6'd16: c = " ";
      6'd17: c = "|";
      6'd18: c = " ";
      6'd19: c = "H";
      6'd20: c = ":";
      6'd21: c = " ";
      6'd22: c = "c";
      6'd23: c = "m";
      6'd24: c = " ";
      6'd25: c = "|";
      6'd26: c = " ";
      6'd27: c = "V";
      6'd28: c = ":";
      6'd29: c = " ";
      6'd30: c = "L";
      6'd31: c = CHAR_CR;
      6'd32: c = CHAR_LF;
      default: c = CHAR_LF;
    endcase
    return c;
  endfunction

  function automatic seg_t seg_info(input logic full, input logic [2:0] seg);
    seg_t s;
    s = '{is_num: 1'b0, first: 6'd30, stop: TXT_LAST, vsel: VAL_VOL};
    if (full) begin
      case (seg)
        3'd0: s = '{is_num: 1'b0, first: 6'd0, stop: 6'd13, vsel: VAL_VOL};
        3'd1: s = '{is_num: 1'b1, first: 6'd0, stop: 6'd0, vsel: VAL_VOL};
        default: s = '{is_num: 1'b0, first: 6'd30, stop: TXT_LAST, vsel: VAL_VOL};
      endcase
    end else begin
      case (seg)
        3'd0: s = '{is_num: 1'b0, first: 6'd0, stop: 6'd2, vsel: VAL_DIST};
        3'd1: s = '{is_num: 1'b1, first: 6'd0, stop: 6'd0, vsel: VAL_DIST};
        3'd2: s = '{is_num: 1'b0, first: 6'd14, stop: 6'd21, vsel: VAL_DIST};
        3'd3: s = '{is_num: 1'b1, first: 6'd0, stop: 6'd0, vsel: VAL_HEIGHT};
        3'd4: s = '{is_num: 1'b0, first: 6'd22, stop: 6'd29, vsel: VAL_DIST};
        3'd5: s = '{is_num: 1'b1, first: 6'd0, stop: 6'd0, vsel: VAL_VOL};
        default: s = '{is_num: 1'b0, first: 6'd30, stop: TXT_LAST, vsel: VAL_VOL};
      endcase
    end
    return s;
  endfunction

endpackage

@@ src/tlf_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on tlf_pkg for the request and response structs and widths.
module tlf_divider (
  input  logic             clk,
  input  logic             rst,
  input  tlf_pkg::div_req_t req,
  output tlf_pkg::div_rsp_t rsp
);
  import tlf_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic busy;
  logic done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic ge;

  assign trial = {rem, acc[NUM_W-1]};
  assign diff = trial - {1'b0, den};
  assign ge = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= req.wide ? CNT_W'(NUM_W) : CNT_W'(NARROW_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= req.wide ? req.num : {req.num[NARROW_W-1:0], {(NUM_W - NARROW_W){1'b0}}};
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quo = acc;
  assign rsp.rem = rem;

endmodule

@@ src/tank_level_text_formatter.sv @@
// Tank level text formatter. Turns an echo count into an ASCII report,
// one character per output transaction. Depends on tlf_pkg and tlf_divider.
//
// Channels: the input transaction (in_valid, in_ready, echo_count) carries
// one echo count; each output transaction (out_valid, out_ready, out_char,
// last) carries one report character, and last marks the final line feed.
// Registers are written through cfg_we, cfg_index and cfg_data; the
// user must write them only while idle; the block does not enforce it.
// All divisions run on one shared restoring divider under a small
// sequencer, and the volume product comes from a separate multiplier.
// The sequencer divides the echo count for the distance, multiplies and
// divides for the volume unless the tank is full, gives each segment a
// setup state and converts each number digit by digit by dividing by ten.
// The block accepts a new echo count only when idle, which it reaches
// right after handing its final character to the output register.
// If the receiver stalls, the character waits in that register and the
// sequencer stops at its next character. Reset empties the output
// register, returns to idle and loads the default register values.
module tank_level_text_formatter #(
  parameter int ECHO_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ECHO_BITS-1:0] echo_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_char,
  output logic                 last,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import tlf_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIST = 4'd1;
  localparam logic [3:0] S_MUL = 4'd2;
  localparam logic [3:0] S_VOLGO = 4'd3;
  localparam logic [3:0] S_VOL = 4'd4;
  localparam logic [3:0] S_SEG = 4'd5;
  localparam logic [3:0] S_TXT = 4'd6;
  localparam logic [3:0] S_CONV = 4'd7;
  localparam logic [3:0] S_NUM = 4'd8;

  logic [7:0] echo_divisor;
  logic [9:0] empty_distance;
  logic [9:0] dead_zone;
  logic [11:0] litres_per_cm_tenths;
  logic [15:0] capacity;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] seg;
  logic [TXT_W-1:0] tidx;
  logic [2:0] sp;
  logic [3:0] digits [DIGITS_MAX];
  logic full;
  logic [15:0] dist_cm;
  logic [9:0] height;
  logic [15:0] vol;
  logic [NUM_W-1:0] prod;

  div_req_t div_req;
  div_rsp_t div_rsp;
  seg_t info;

  logic can_load;
  logic [15:0] q16;
  logic [15:0] num_val;
  logic [2:0] top_idx;

  tlf_divider u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign info = seg_info(full, seg);
  assign can_load = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign q16 = div_rsp.quo[15:0];
  assign top_idx = sp - 3'd1;

  always_comb begin
    case (info.vsel)
      VAL_DIST: num_val = dist_cm;
      VAL_HEIGHT: num_val = {6'b0, height};
      default: num_val = vol;
    endcase
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.wide = 1'b0;
    div_req.num = NUM_W'(num_val);
    div_req.den = DEC_BASE;
    case (state)
      S_IDLE: begin
        div_req.start = in_valid;
        div_req.num = NUM_W'(echo_count);
        div_req.den = (echo_divisor == '0) ? DEN_W'(1) : echo_divisor;
      end
      S_VOLGO: begin
        div_req.start = 1'b1;
        div_req.wide = 1'b1;
        div_req.num = prod;
      end
      S_SEG: begin
        div_req.start = info.is_num;
      end
      S_CONV: begin
        div_req.start = div_rsp.done && (div_rsp.quo != '0);
        div_req.num = div_rsp.quo;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DIST;
      S_DIST: begin
        if (div_rsp.done) begin
          state_next = (q16 < {6'b0, dead_zone}) ? S_SEG : S_MUL;
        end
      end
      S_MUL: state_next = S_VOLGO;
      S_VOLGO: state_next = S_VOL;
      S_VOL: if (div_rsp.done) state_next = S_SEG;
      S_SEG: state_next = info.is_num ? S_CONV : S_TXT;
      S_TXT: begin
        if (can_load && tidx == info.stop) begin
          state_next = (tidx == TXT_LAST) ? S_IDLE : S_SEG;
        end
      end
      S_CONV: if (div_rsp.done && div_rsp.quo == '0) state_next = S_NUM;
      S_NUM: if (can_load && sp == 3'd1) state_next = S_SEG;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      echo_divisor <= RST_ECHO_DIVISOR;
      empty_distance <= RST_EMPTY_DISTANCE;
      dead_zone <= RST_DEAD_ZONE;
      litres_per_cm_tenths <= RST_LITRES_PER_CM;
      capacity <= RST_CAPACITY;
      seg <= '0;
      sp <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_ECHO_DIVISOR: echo_divisor <= cfg_data[7:0];
          REG_EMPTY_DISTANCE: empty_distance <= cfg_data[9:0];
          REG_DEAD_ZONE: dead_zone <= cfg_data[9:0];
          REG_LITRES_PER_CM: litres_per_cm_tenths <= cfg_data[11:0];
          REG_CAPACITY: capacity <= cfg_data;
          default: ;
        endcase
      end
      if ((state == S_TXT || state == S_NUM) && can_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_DIST: seg <= '0;
        S_SEG: sp <= '0;
        S_TXT: if (can_load && tidx == info.stop) seg <= seg + 3'd1;
        S_CONV: if (div_rsp.done) sp <= sp + 3'd1;
        S_NUM: begin
          if (can_load) begin
            sp <= sp - 3'd1;
            if (sp == 3'd1) seg <= seg + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_DIST: begin
        if (div_rsp.done) begin
          dist_cm <= q16;
          full <= q16 < {6'b0, dead_zone};
          height <= ({6'b0, empty_distance} > q16) ? empty_distance - q16[9:0] : '0;
          vol <= capacity;
        end
      end
      S_MUL: prod <= {12'b0, height} * {10'b0, litres_per_cm_tenths};
      S_VOL: begin
        if (div_rsp.done) begin
          vol <= (div_rsp.quo > NUM_W'(capacity)) ? capacity : q16;
        end
      end
      S_SEG: tidx <= info.first;
      S_TXT: begin
        if (can_load) begin
          out_char <= txt_char(tidx);
          last <= (tidx == TXT_LAST);
          tidx <= tidx + 1'b1;
        end
      end
      S_CONV: if (div_rsp.done) digits[sp] <= div_rsp.rem[3:0];
      S_NUM: begin
        if (can_load) begin
          out_char <= CHAR_ZERO | {4'b0, digits[top_idx]};
          last <= 1'b0;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block still ready after accepting an echo count");

  a_done_in_wait_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIST || state == S_VOL || state == S_CONV))
    else $error("divider finished outside a waiting state");

  a_digit_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= 3'(DIGITS_MAX))
    else $error("digit stack overflow");

  a_last_is_line_feed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (out_char == CHAR_LF))
    else $error("final character is not a line feed");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for tank_level_text_formatter: echo counts go in, report text is
// predicted per transaction and compared character by character. Depends on tlf_pkg.
module tb_top;
  import tlf_pkg::*;

  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST = 3'd7;

  class tank_report_predictor;
    logic [7:0]  echo_div;
    logic [9:0]  empty_cm;
    logic [9:0]  dead_cm;
    logic [11:0] tenths_per_cm;
    logic [15:0] capacity_l;
    logic [7:0]  line_buf[$];
    logic [7:0]  char_due[$];
    logic        last_due[$];
    int          echoes_taken;
    int          errors;

    function new();
      echo_div = RST_ECHO_DIVISOR;
      empty_cm = RST_EMPTY_DISTANCE;
      dead_cm = RST_DEAD_ZONE;
      tenths_per_cm = RST_LITRES_PER_CM;
      capacity_l = RST_CAPACITY;
      echoes_taken = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_ECHO_DIVISOR: echo_div = data[7:0];
        REG_EMPTY_DISTANCE: empty_cm = data[9:0];
        REG_DEAD_ZONE: dead_cm = data[9:0];
        REG_LITRES_PER_CM: tenths_per_cm = data[11:0];
        REG_CAPACITY: capacity_l = data[15:0];
        default: ;
      endcase
    endfunction

    function void put_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function void put_decimal(int unsigned v);
      logic [7:0] digits[$];
      if (v == 0) digits.push_front(CHAR_ZERO);
      while (v > 0) begin
        digits.push_front(CHAR_ZERO + 8'(v % 10));
        v = v / 10;
      end
      foreach (digits[i]) line_buf.push_back(digits[i]);
    endfunction

    function void add_echo(logic [15:0] echo);
      int unsigned divisor;
      int unsigned dist_cm;
      int unsigned height;
      int unsigned vol;
      divisor = (echo_div == 0) ? 1 : echo_div;
      dist_cm = echo / divisor;
      line_buf.delete();
      if (dist_cm < dead_cm) begin
        put_text("D: LLENO | V: ");
        put_decimal(capacity_l);
      end else begin
        height = (empty_cm > dist_cm) ? empty_cm - dist_cm : 0;
        vol = height * tenths_per_cm / 10;
        if (vol > capacity_l) vol = capacity_l;
        put_text("D: ");
        put_decimal(dist_cm);
        put_text("cm | H: ");
        put_decimal(height);
        put_text("cm | V: ");
        put_decimal(vol);
      end
      put_text("L");
      line_buf.push_back(CHAR_CR);
      line_buf.push_back(CHAR_LF);
      foreach (line_buf[i]) begin
        char_due.push_back(line_buf[i]);
        last_due.push_back(i == line_buf.size() - 1);
      end
      echoes_taken++;
    endfunction

    function void check_char(logic [7:0] c, logic l);
      logic [7:0] exp_c;
      logic       exp_l;
      if (char_due.size() == 0) begin
        errors++;
        $error("out_char: expected nothing, got %h", c);
        return;
      end
      exp_c = char_due.pop_front();
      exp_l = last_due.pop_front();
      if (c !== exp_c) begin
        errors++;
        $error("out_char: expected %h, got %h", exp_c, c);
      end
      if (l !== exp_l) begin
        errors++;
        $error("last: expected %b, got %b", exp_l, l);
      end
    endfunction

    function int pending();
      return char_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] echo_count;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_char;
  logic        last;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  tank_report_predictor board = new();
  int burst_left = 0;

  tank_level_text_formatter i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .echo_count(echo_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .last(last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("tb_top: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_char(out_char, last);
  end

  // The receiver changes its stall pattern now and then and holds off once for a long
  // stretch so that the block backs up into its input channel.
  initial begin
    int mode;
    int span;
    int stall_cnt;
    int hold_left;
    bit held;
    stall_cnt = 0;
    hold_left = 0;
    held = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(50, 300);
      repeat (span) begin
        @(negedge clk);
        if (!held && board.echoes_taken >= 40) begin
          held = 1'b1;
          hold_left = 600;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else if (mode == 0) begin
          out_ready <= 1'b1;
        end else if (mode == 1) begin
          out_ready <= 1'($urandom_range(0, 1));
        end else if (stall_cnt > 0) begin
          stall_cnt--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_cnt = $urandom_range(1, 12);
        end
      end
    end
  end

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value, input int width);
    logic [15:0] keep;
    logic [15:0] data;
    keep = 16'((32'd1 << width) - 1);
    data = value & keep;
    if ($urandom_range(0, 1) == 1) data = data | (16'($urandom) & ~keep);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    board.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_regs(input int div, input int empty, input int dead, input int lpc,
                              input int cap);
    wait_idle();
    write_reg(REG_ECHO_DIVISOR, 16'(div), 8);
    write_reg(REG_EMPTY_DISTANCE, 16'(empty), 10);
    write_reg(REG_DEAD_ZONE, 16'(dead), 10);
    write_reg(REG_LITRES_PER_CM, 16'(lpc), 12);
    write_reg(REG_CAPACITY, 16'(cap), 16);
    write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 16'($urandom), 16);
    cfg_we <= 1'b0;
  endtask

  task automatic send_echo(input logic [15:0] echo);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 6);
    end
    in_valid <= 1'b1;
    echo_count <= echo;
    do @(posedge clk); while (!in_ready);
    board.add_echo(echo);
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_echo();
    int unsigned d;
    int unsigned e;
    int r;
    d = (board.echo_div == 0) ? 1 : board.echo_div;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      e = $urandom_range(0, 65535);
    end else if (r < 30 && board.dead_cm > 0) begin
      e = $urandom_range(0, board.dead_cm * d - 1);
    end else begin
      e = $urandom_range(board.dead_cm, board.empty_cm + 20) * d + $urandom_range(0, d - 1);
    end
    if (e > 65535) e = 65535;
    return 16'(e);
  endfunction

  initial begin
    int phase;
    int r_div;
    int r_cap;
    rst = 1'b1;
    in_valid = 1'b0;
    echo_count = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ECHO_DIVISOR;
    cfg_data = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: full tank edge, height reaching zero, volume capped.
    send_echo(16'd0);
    send_echo(16'd59);
    send_echo(16'd60);
    send_echo(16'd62);
    send_echo(16'd300);
    send_echo(16'd660);
    send_echo(16'd663);
    send_echo(16'hAAAA);
    send_echo(16'h5555);
    send_echo(16'hFFFF);

    // Widest numbers, no dead zone.
    program_regs(1, 1023, 0, 4095, 65535);
    send_echo(16'd0);
    send_echo(16'd1000);
    send_echo(16'd1022);
    send_echo(16'd1023);
    send_echo(16'hFFFF);

    // Zero divisor, zero capacity and the largest dead zone.
    program_regs(0, 0, 1023, 0, 0);
    send_echo(16'd1022);
    send_echo(16'd1023);
    send_echo(16'hFFFF);

    program_regs(255, 500, 1, 1, 9);
    send_echo(16'd254);
    send_echo(16'd255);
    send_echo(16'hFFFF);

    for (phase = 0; phase < 8; phase++) begin
      r_div = $urandom_range(0, 9);
      r_cap = $urandom_range(0, 9);
      program_regs(r_div == 0 ? 0 : (r_div == 1 ? 255 : $urandom_range(1, 40)),
                   $urandom_range(0, 1023),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40),
                   $urandom_range(0, 4095),
                   r_cap == 0 ? 0 : (r_cap == 1 ? 65535 : $urandom_range(0, 65535)));
      repeat (50) send_echo(pick_echo());
    end

    wait_idle();
    repeat (32) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
